/* rtl/tsh_pkg.sv */
`default_nettype none

package tsh_pkg;

   localparam int WORD_W    = 32;
   localparam int BLOCK_LEN = 4;
   localparam int ROUND_W   = 4;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [BLOCK_LEN-1:0] block_type;
   typedef logic [ROUND_W-1:0] round_type;

   localparam word_type TEA_DELTA    = 32'h9E37_79B9;
   localparam word_type CHAIN_A_INIT = 32'h9464_a485;
   localparam word_type CHAIN_B_INIT = 32'h542e_1a94;

   localparam round_type BLOCK_ROUNDS = 4'd6;
   localparam round_type FINAL_ROUNDS = 4'd10;

   // Commands from the sequencer to the block store
   typedef struct packed {
      logic write_byte;
      logic load_final;
      logic clear;
   } store_ctrl_type;

   // Store status back to the sequencer
   typedef struct packed {
      logic last_lane;
   } store_stat_type;

   // Round unit half-round select
   typedef enum logic {
      PHASE_X = 1'b0,
      PHASE_Y = 1'b1
   } phase_type;

endpackage

`default_nettype wire

/* rtl/tsh_if.sv */
`default_nettype none

interface tsh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       last_byte;

   modport source (output valid, output data_byte, output byte_present, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_present, input last_byte,
                   output ready);
endinterface

interface tsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

/* rtl/tea_string_hash.sv */
`default_nettype none
// A byte that does not complete a block is only stored.
// A byte completing a 16-byte block starts the block rounds (one half-round per cycle), then a fold.
// The last item adds a closing-block build, the final rounds, a fold and the output step.
// Throughput is limited by the single shared half-round unit; ready is low whenever the sequencer is not idle.
// Reset (synchronous, active high) restores chains, fill and length; sign extension is on.
module tea_string_hash (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_write_enable,
   input  wire [31:0] csr_write_data,
   tsh_req_if.sink    req_channel,
   tsh_rsp_if.source  rsp_channel
);
   import tsh_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MIX   = 5'b00010,
      S_FOLD  = 5'b00100,
      S_FINAL = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   word_type       chain_a_ff, chain_a_in;
   word_type       chain_b_ff, chain_b_in;
   word_type       x_ff, x_in;
   word_type       y_ff, y_in;
   word_type       acc_ff, acc_in;
   phase_type      phase_ff, phase_in;
   round_type      round_ff, round_in;
   logic           pending_ff, pending_in;
   logic           final_mix_ff, final_mix_in;
   logic           sign_ff, sign_in;
   logic           rsp_valid_ff, rsp_valid_in;
   word_type       rsp_hash_ff, rsp_hash_in;

   store_ctrl_type store_ctrl;
   store_stat_type store_stat;
   block_type      words;
   word_type       unit_result;
   logic           req_transfer;

   tsh_block_store u_store (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (store_ctrl),
      .data_byte   (req_channel.data_byte),
      .sign_extend (sign_ff),
      .words       (words),
      .stat        (store_stat)
   );

   tsh_round_unit u_round (
      .phase   (phase_ff),
      .x_val   (x_ff),
      .y_val   (y_ff),
      .acc_val (acc_ff),
      .words   (words),
      .result  (unit_result)
   );

   assign req_channel.ready = (state_ff == S_IDLE);
   assign req_transfer      = req_channel.valid && req_channel.ready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      chain_a_in   = chain_a_ff;
      chain_b_in   = chain_b_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      phase_in     = phase_ff;
      round_in     = round_ff;
      pending_in   = pending_ff;
      final_mix_in = final_mix_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
      store_ctrl   = '0;
      sign_in      = csr_write_enable ? csr_write_data[0] : sign_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_transfer) begin
               store_ctrl.write_byte = req_channel.byte_present;
               if (req_channel.byte_present && store_stat.last_lane) begin
                  x_in         = chain_a_ff;
                  y_in         = chain_b_ff;
                  acc_in       = TEA_DELTA;
                  phase_in     = PHASE_X;
                  round_in     = BLOCK_ROUNDS - 4'd1;
                  pending_in   = req_channel.last_byte;
                  final_mix_in = 1'b0;
                  state_in     = S_MIX;
               end else if (req_channel.last_byte) begin
                  state_in = S_FINAL;
               end
            end
         end
         S_MIX: begin
            // Advance one half-round through the shared unit
            if (phase_ff == PHASE_X) begin
               x_in     = unit_result;
               phase_in = PHASE_Y;
            end else begin
               y_in     = unit_result;
               phase_in = PHASE_X;
               acc_in   = acc_ff + TEA_DELTA;
               round_in = round_ff - 4'd1;
               if (round_ff == '0) begin
                  state_in = S_FOLD;
               end
            end
         end
         S_FOLD: begin
            chain_a_in = chain_a_ff + x_ff;
            chain_b_in = chain_b_ff + y_ff;
            priority if (final_mix_ff) begin
               state_in = S_OUT;
            end else if (pending_ff) begin
               pending_in = 1'b0;
               state_in   = S_FINAL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FINAL: begin
            store_ctrl.load_final = 1'b1;
            x_in         = chain_a_ff;
            y_in         = chain_b_ff;
            acc_in       = TEA_DELTA;
            phase_in     = PHASE_X;
            round_in     = FINAL_ROUNDS - 4'd1;
            final_mix_in = 1'b1;
            state_in     = S_MIX;
         end
         S_OUT: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || rsp_channel.ready) begin
               rsp_hash_in      = chain_a_ff ^ chain_b_ff;
               rsp_valid_in     = 1'b1;
               chain_a_in       = CHAIN_A_INIT;
               chain_b_in       = CHAIN_B_INIT;
               final_mix_in     = 1'b0;
               store_ctrl.clear = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      acc_ff      <= acc_in;
      phase_ff    <= phase_in;
      round_ff    <= round_in;
      rsp_hash_ff <= rsp_hash_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         chain_a_ff   <= CHAIN_A_INIT;
         chain_b_ff   <= CHAIN_B_INIT;
         pending_ff   <= 1'b0;
         final_mix_ff <= 1'b0;
         sign_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_a_ff   <= chain_a_in;
         chain_b_ff   <= chain_b_in;
         pending_ff   <= pending_in;
         final_mix_ff <= final_mix_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_channel.valid      = rsp_valid_ff;
   assign rsp_channel.hash_value = rsp_hash_ff;

endmodule

`default_nettype wire

/* rtl/tsh_round_unit.sv */
`default_nettype none

module tsh_round_unit (
   input  wire tsh_pkg::phase_type phase,
   input  wire tsh_pkg::word_type  x_val,
   input  wire tsh_pkg::word_type  y_val,
   input  wire tsh_pkg::word_type  acc_val,
   input  wire tsh_pkg::block_type words,
   output tsh_pkg::word_type       result
);
   import tsh_pkg::*;

   word_type dst;
   word_type src;
   word_type key_lo;
   word_type key_hi;

   // Pick operands for the half-round: x updates from y, y from x
   always_comb begin
      unique case (phase)
         PHASE_X: begin
            dst    = x_val;
            src    = y_val;
            key_lo = words[0];
            key_hi = words[1];
         end
         PHASE_Y: begin
            dst    = y_val;
            src    = x_val;
            key_lo = words[2];
            key_hi = words[3];
         end
         default: begin
            dst    = x_val;
            src    = y_val;
            key_lo = words[0];
            key_hi = words[1];
         end
      endcase
   end

   // One TEA half-round
   assign result = dst + (((src << 4) + key_lo) ^ (src + acc_val) ^ ((src >> 5) + key_hi));

endmodule

`default_nettype wire

/* rtl/tsh_block_store.sv */
`default_nettype none

module tsh_block_store (
   input  wire                          clock,
   input  wire                          reset,
   input  wire tsh_pkg::store_ctrl_type ctrl,
   input  wire [7:0]                    data_byte,
   input  wire                          sign_extend,
   output tsh_pkg::block_type           words,
   output tsh_pkg::store_stat_type      stat
);
   import tsh_pkg::*;

   block_type   words_ff, words_in;
   logic [3:0]  fill_ff, fill_in;
   word_type    length_ff, length_in;

   logic [1:0]  word_idx;
   logic [1:0]  lane_idx;
   word_type    pad_lo;
   word_type    pad;
   word_type    tail_word;
   word_type    tail_byte;
   block_type   final_words;

   assign word_idx = fill_ff[3:2];
   assign lane_idx = fill_ff[1:0];

   // Build the padding word, the tail word and the closing block
   always_comb begin
      pad_lo    = length_ff | (length_ff << 8);
      pad       = pad_lo | (pad_lo << 16);
      tail_word = pad;
      for (int k = 0; k < 3; k++) begin
         tail_byte = {24'h00_0000, words_ff[word_idx][8*k +: 8]};
         if (sign_extend && tail_byte[7]) begin
            tail_byte = tail_byte | 32'hFFFF_FF00;
         end
         if (k < int'(lane_idx)) begin
            tail_word = (tail_word << 8) | tail_byte;
         end
      end
      for (int j = 0; j < BLOCK_LEN; j++) begin
         if (j < int'(word_idx)) begin
            final_words[j] = words_ff[j];
         end else if (j == int'(word_idx)) begin
            final_words[j] = tail_word;
         end else begin
            final_words[j] = pad;
         end
      end
   end

   // Pack bytes, swap in the final block, or drop the message
   always_comb begin
      words_in  = words_ff;
      fill_in   = fill_ff;
      length_in = length_ff;
      priority if (ctrl.clear) begin
         fill_in   = '0;
         length_in = '0;
      end else if (ctrl.load_final) begin
         words_in = final_words;
      end else if (ctrl.write_byte) begin
         if (lane_idx == 2'd0) begin
            words_in[word_idx] = {24'h00_0000, data_byte};
         end else begin
            words_in[word_idx] = words_ff[word_idx] |
                                 ({24'h00_0000, data_byte} << {lane_idx, 3'b000});
         end
         fill_in   = fill_ff + 4'd1;
         length_in = length_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
      if (reset) begin
         fill_ff   <= '0;
         length_ff <= '0;
      end else begin
         fill_ff   <= fill_in;
         length_ff <= length_in;
      end
   end

   assign words          = words_ff;
   assign stat.last_lane = (fill_ff == 4'd15);

endmodule

`default_nettype wire

/* verif/hash_check_pkg.sv */
`timescale 1ns / 100ps

package hash_check_pkg;
   import tsh_pkg::*;

   // Tracks the running hash of the current message and the hashes still owed by the block
   class hash_ledger;
      bit       sign_tail;
      word_type chain_a;
      word_type chain_b;
      word_type lanes [BLOCK_LEN];
      logic [3:0] fill;
      word_type msg_len;
      word_type pending_hashes [$];
      int       errors;

      function new();
         sign_tail = 1'b1;
         errors    = 0;
         clear_message();
      endfunction

      function void clear_message();
         chain_a = CHAIN_A_INIT;
         chain_b = CHAIN_B_INIT;
         foreach (lanes[j]) lanes[j] = '0;
         fill    = '0;
         msg_len = '0;
      endfunction

      // Run the TEA-style rounds over one block and fold them into the chains
      function void mix_rounds(word_type w [BLOCK_LEN], int unsigned rounds);
         word_type x;
         word_type y;
         word_type acc;
         x   = chain_a;
         y   = chain_b;
         acc = '0;
         for (int unsigned r = 0; r < rounds; r++) begin
            acc = acc + TEA_DELTA;
            x = x + (((y << 4) + w[0]) ^ (y + acc) ^ ((y >> 5) + w[1]));
            y = y + (((x << 4) + w[2]) ^ (x + acc) ^ ((x >> 5) + w[3]));
         end
         chain_a = chain_a + x;
         chain_b = chain_b + y;
      endfunction

      // Build the closing block (whole words, the tail word over the padding, then padding), mix it, return the hash
      function word_type close_message();
         word_type closing [BLOCK_LEN];
         word_type pad;
         word_type v;
         word_type tail_b;
         int unsigned whole;
         int unsigned tail;
         pad   = msg_len | (msg_len << 8);
         pad   = pad | (pad << 16);
         whole = 32'(fill[3:2]);
         tail  = 32'(fill[1:0]);
         for (int unsigned j = 0; j < BLOCK_LEN; j++) begin
            if (j < whole) begin
               closing[j] = lanes[j];
            end else if (j == whole) begin
               v = pad;
               for (int unsigned k = 0; k < tail; k++) begin
                  tail_b = {24'd0, lanes[j][8*k +: 8]};
                  // Treat tail bytes as signed char when the mode asks for it
                  if (sign_tail && tail_b[7]) begin
                     tail_b[31:8] = '1;
                  end
                  v = (v << 8) | tail_b;
               end
               closing[j] = v;
            end else begin
               closing[j] = pad;
            end
         end
         mix_rounds(closing, FINAL_ROUNDS);
         return chain_a ^ chain_b;
      endfunction

      // Absorb one accepted transfer; queue a hash when it ends the message
      function void accept_item(logic [7:0] data_b, bit present, bit last);
         int unsigned idx;
         int unsigned lane;
         if (present) begin
            idx  = 32'(fill[3:2]);
            lane = 32'(fill[1:0]);
            if (lane == 0) begin
               lanes[idx] = {24'd0, data_b};
            end else begin
               lanes[idx][8*lane +: 8] = data_b;
            end
            msg_len = msg_len + 32'd1;
            if (fill == 4'd15) begin
               mix_rounds(lanes, BLOCK_ROUNDS);
            end
            fill = fill + 4'd1;
         end
         if (last) begin
            pending_hashes.push_back(close_message());
            clear_message();
         end
      endfunction

      function void check_hash(word_type got);
         word_type want;
         if (pending_hashes.size() == 0) begin
            errors++;
            if (errors <= 10) $display("hash %08h arrived with none pending", got);
            return;
         end
         want = pending_hashes.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("hash_value mismatch: expected %08h got %08h", want, got);
         end
      endfunction

      function int pending();
         return pending_hashes.size();
      endfunction
   endclass

endpackage

/* verif/tea_string_hash_tb.sv */
`timescale 1ns / 100ps

module tea_string_hash_tb;
   import tsh_pkg::*;
   import hash_check_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int LONG_HOLD     = 300;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   tsh_req_if req_ch ();
   tsh_rsp_if rsp_ch ();

   hash_ledger  ledger;
   int unsigned cycle_count = 0;
   int          items_sent;
   bit          sender_idle;
   bit          sink_idle;
   bit          long_hold_request;

   tea_string_hash dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_ch),
      .rsp_channel      (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tea_string_hash_tb: errors");
         $finish;
      end
   end

   // Drive one item and hold it until the block takes the transfer
   task send_item(logic [7:0] data_b, bit present, bit last);
      if (sender_idle && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= data_b;
      req_ch.byte_present <= present;
      req_ch.last_byte    <= last;
      do @(posedge clock); while (!req_ch.ready);
      ledger.accept_item(data_b, present, last);
      if (present || last) items_sent++;
   endtask

   // Message with random content, sprinkled with idle items
   task send_message(int unsigned len, bit end_marker);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !end_marker);
      end
      if (end_marker || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Three tail bytes, two of them with the top bit set
   task send_tail_probe();
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h7F, 1'b1, 1'b1);
   endtask

   // Wait until the block is drained, then write the tail mode
   task write_tail_mode(bit mode);
      logic [31:0] wdata;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      wdata            = $urandom;
      wdata[0]         = mode;
      csr_write_enable <= 1'b1;
      csr_write_data   <= wdata;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ledger.sign_tail = mode;
   endtask

   task run_phase(int target, bit mode, bit hold);
      int unsigned len;
      write_tail_mode(mode);
      if (hold) long_hold_request = 1'b1;
      while (items_sent < target) begin
         // Mostly short messages, a few that span several blocks
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 80) : $urandom_range(0, 32);
         sender_idle = sink_idle && ($urandom_range(0, 3) != 0);
         send_message(len, $urandom_range(0, 1));
      end
      req_ch.valid <= 1'b0;
   endtask

   // Result side: random stall bursts plus one long hold-off
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) ledger.check_hash(rsp_ch.hash_value);
         if (long_hold_request) begin
            hold_left         = LONG_HOLD;
            long_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (sink_idle && $urandom_range(0, 5) == 0) begin
            hold_left    = $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      ledger              = new();
      items_sent          = 0;
      sender_idle         = 1'b1;
      sink_idle           = 1'b1;
      long_hold_request   = 1'b0;
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.data_byte    <= '0;
      req_ch.byte_present <= 1'b0;
      req_ch.last_byte    <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty message, idle item, single byte, signed tail, one full block, then an unsigned tail
      send_item(8'hA5, 1'b0, 1'b1);
      send_item(8'h3C, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      send_tail_probe();
      for (int i = 0; i < 16; i++) begin
         send_item(8'($urandom_range(0, 255)), 1'b1, i == 15);
      end
      send_item(8'h00, 1'b0, 1'b1);
      req_ch.valid <= 1'b0;
      write_tail_mode(1'b0);
      send_tail_probe();
      req_ch.valid <= 1'b0;

      // Random messages over both tail modes; the last stretch runs without idling
      items_sent = 0;
      run_phase(RANDOM_ITEMS / 4, 1'b1, 1'b0);
      run_phase(RANDOM_ITEMS / 2, 1'b0, 1'b1);
      run_phase(3 * RANDOM_ITEMS / 4, 1'b1, 1'b0);
      sink_idle = 1'b0;
      run_phase(RANDOM_ITEMS, 1'b0, 1'b0);

      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.errors == 0) begin
         $display("tea_string_hash_tb: clean");
      end else begin
         $display("tea_string_hash_tb: errors");
      end
      $finish;
   end

endmodule
